### rtl/core/psfc_pkg.sv
// Shared types, format codes and helpers for the PCM sample format converter.
// No dependencies; every core file imports this package.
package psfc_pkg;

  localparam logic [2:0] FMT_I16 = 3'd0;
  localparam logic [2:0] FMT_I32 = 3'd1;
  localparam logic [2:0] FMT_F32 = 3'd2;
  localparam logic [2:0] FMT_F64 = 3'd3;

  // Signed exponent wide enough for every intermediate sum.
  typedef logic signed [13:0] exp_t;

  // Decoded request: either a finished direct result or a finite nonzero
  // magnitude with value mag * 2^(e - 63).
  typedef struct packed {
    logic        last;
    logic        err;
    logic        direct;
    logic        clip;
    logic [63:0] res;
    logic        sign;
    logic [63:0] mag;
    exp_t        e;
    logic [2:0]  tf;
  } psfc_dec_t;

  // Aligned request ahead of rounding and packing.
  typedef struct packed {
    logic        last;
    logic        err;
    logic        direct;
    logic        clip;
    logic [63:0] res;
    logic        sign;
    logic [2:0]  tf;
    logic [63:0] q;
    logic        rnd;
    logic        sticky;
    exp_t        ebase;
    logic        ovf;
    logic        ibig;
  } psfc_shf_t;

  // Saturation limit of an integer target, as raw bits of that width.
  function automatic logic [63:0] int_sat(input logic sign, input logic is32);
    logic [63:0] r;
    if (is32) begin
      r = sign ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    end else begin
      r = sign ? 64'h0000_0000_0000_8000 : 64'h0000_0000_0000_7FFF;
    end
    return r;
  endfunction

endpackage

### rtl/core/psfc_decode.sv
// First pipeline stage: unpack the source format and resolve all direct cases.
// Depends on psfc_pkg.
module psfc_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [63:0]      sample,
  input  logic             last,
  input  logic [2:0]       sf,
  input  logic [2:0]       tf,
  output logic             out_valid,
  output psfc_pkg::psfc_dec_t out_item
);
  import psfc_pkg::*;

  psfc_dec_t d;

  always_comb begin
    logic        s32;
    logic        s64;
    logic [7:0]  ef32;
    logic [10:0] ef64;
    logic        tint;
    logic        nan;
    d = '0;
    d.last = last;
    d.tf = tf;
    s32 = sample[31];
    s64 = sample[63];
    ef32 = sample[30:23];
    ef64 = sample[62:52];
    tint = (tf == FMT_I16) || (tf == FMT_I32);
    nan = 1'b0;
    if (sf > FMT_F64 || tf > FMT_F64) begin
      d.err = 1'b1;
      d.direct = 1'b1;
    end else if (sf == tf) begin
      d.direct = 1'b1;
      if (sf == FMT_I16) d.res = {48'd0, sample[15:0]};
      else if (sf == FMT_F64) d.res = sample;
      else d.res = {32'd0, sample[31:0]};
    end else if (sf == FMT_I16 || sf == FMT_I32) begin
      if (tint) begin
        d.direct = 1'b1;
        if (tf == FMT_I32) d.res = {32'd0, sample[15:0], 16'd0};
        else d.res = {48'd0, sample[31:16]};
      end else if (sf == FMT_I16) begin
        d.sign = sample[15];
        d.mag = d.sign ? (64'd0 - {{48{1'b1}}, sample[15:0]}) : {48'd0, sample[15:0]};
        d.e = exp_t'(48);
        d.direct = (sample[15:0] == 16'd0);
      end else begin
        d.sign = sample[31];
        d.mag = d.sign ? (64'd0 - {{32{1'b1}}, sample[31:0]}) : {32'd0, sample[31:0]};
        d.e = exp_t'(32);
        d.direct = (sample[31:0] == 32'd0);
      end
    end else begin
      // Float source: specials and zero resolve here.
      if (sf == FMT_F32) begin
        d.sign = s32;
        nan = (sample[22:0] != 23'd0);
        if (ef32 == 8'hFF) begin
          d.direct = 1'b1;
        end else if (ef32 == 8'd0) begin
          d.mag = {41'd0, sample[22:0]};
          d.e = -exp_t'(86);
        end else begin
          d.mag = {40'd0, 1'b1, sample[22:0]};
          d.e = exp_t'(ef32) - exp_t'(87);
        end
        if (ef32 == 8'hFF) begin
          if (tint) begin
            d.clip = 1'b1;
            d.res = nan ? 64'd0 : int_sat(s32, tf == FMT_I32);
          end else begin
            d.res = {s32, 11'h7FF, nan, (nan ? sample[21:0] : 22'd0), 29'd0};
          end
        end
      end else begin
        d.sign = s64;
        nan = (sample[51:0] != 52'd0);
        if (ef64 == 11'h7FF) begin
          d.direct = 1'b1;
        end else if (ef64 == 11'd0) begin
          d.mag = {12'd0, sample[51:0]};
          d.e = -exp_t'(1011);
        end else begin
          d.mag = {11'd0, 1'b1, sample[51:0]};
          d.e = exp_t'(ef64) - exp_t'(1012);
        end
        if (ef64 == 11'h7FF) begin
          if (tint) begin
            d.clip = 1'b1;
            d.res = nan ? 64'd0 : int_sat(s64, tf == FMT_I32);
          end else begin
            d.res = {32'd0, s64, 8'hFF, nan, (nan ? sample[50:29] : 22'd0)};
          end
        end
      end
      if (!d.direct && d.mag == 64'd0) begin
        d.direct = 1'b1;
        if (tf == FMT_F32) d.res = {32'd0, d.sign, 31'd0};
        else if (tf == FMT_F64) d.res = {d.sign, 63'd0};
        else d.res = 64'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_item <= d;
  end

endmodule

### rtl/core/psfc_norm.sv
// Two pipeline stages that normalize the magnitude, three shift steps each.
// Depends on psfc_pkg.
module psfc_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  psfc_pkg::psfc_dec_t in_item,
  output logic             out_valid,
  output psfc_pkg::psfc_dec_t out_item
);
  import psfc_pkg::*;

  psfc_dec_t mid;
  psfc_dec_t mid_next;
  psfc_dec_t fin_next;
  logic      mid_valid;

  // Coarse steps: 32, 16, 8.
  always_comb begin
    mid_next = in_item;
    for (int k = 5; k >= 3; k--) begin
      if ((mid_next.mag >> (64 - (1 << k))) == 64'd0) begin
        mid_next.mag = mid_next.mag << (1 << k);
        mid_next.e = mid_next.e - exp_t'(1 << k);
      end
    end
  end

  // Fine steps: 4, 2, 1.
  always_comb begin
    fin_next = mid;
    for (int k = 2; k >= 0; k--) begin
      if ((fin_next.mag >> (64 - (1 << k))) == 64'd0) begin
        fin_next.mag = fin_next.mag << (1 << k);
        fin_next.e = fin_next.e - exp_t'(1 << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
    mid <= mid_next;
    out_item <= fin_next;
  end

endmodule

### rtl/core/psfc_round.sv
// Last two pipeline stages: align to the target grid, then round and pack.
// Depends on psfc_pkg.
module psfc_round (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  psfc_pkg::psfc_dec_t in_item,
  output logic             done,
  output logic [63:0]      sample_out,
  output logic             last_out,
  output logic             clipped,
  output logic             format_error
);
  import psfc_pkg::*;

  psfc_shf_t s;
  psfc_shf_t s_next;
  logic      s_valid;
  logic [63:0] res_next;
  logic        clip_next;

  always_comb begin
    logic         f32;
    logic         tint;
    exp_t         fbits;
    exp_t         bias;
    exp_t         maxexp;
    exp_t         eb;
    exp_t         shw;
    exp_t         t;
    logic [127:0] wide;
    f32 = (in_item.tf == FMT_F32);
    tint = (in_item.tf == FMT_I16) || (in_item.tf == FMT_I32);
    fbits = f32 ? exp_t'(23) : exp_t'(52);
    bias = f32 ? exp_t'(127) : exp_t'(1023);
    maxexp = f32 ? exp_t'(255) : exp_t'(2047);
    s_next = '0;
    s_next.last = in_item.last;
    s_next.err = in_item.err;
    s_next.direct = in_item.direct;
    s_next.clip = in_item.clip;
    s_next.res = in_item.res;
    s_next.sign = in_item.sign;
    s_next.tf = in_item.tf;
    eb = in_item.e + bias;
    if (eb > exp_t'(0)) begin
      s_next.ebase = eb - exp_t'(1);
      shw = exp_t'(63) - fbits;
    end else begin
      s_next.ebase = '0;
      shw = exp_t'(64) - fbits - eb;
    end
    if (shw > exp_t'(127)) shw = exp_t'(127);
    s_next.ovf = (s_next.ebase >= maxexp - exp_t'(1));
    wide = {in_item.mag, 64'd0} >> shw[6:0];
    t = in_item.e + ((in_item.tf == FMT_I32) ? exp_t'(31) : exp_t'(15));
    if (tint) begin
      if (t < exp_t'(0)) begin
        s_next.q = 64'd0;
      end else if (t > exp_t'(32)) begin
        s_next.ibig = 1'b1;
      end else begin
        s_next.q = in_item.mag >> (7'd63 - t[6:0]);
      end
    end else begin
      s_next.q = wide[127:64];
      s_next.rnd = wide[63];
      s_next.sticky = |wide[62:0];
    end
  end

  always_comb begin
    logic        f32;
    logic [5:0]  fsh;
    logic [63:0] qr;
    logic [63:0] bits;
    logic [63:0] infb;
    logic [63:0] lim;
    logic [63:0] imag;
    logic [63:0] ival;
    f32 = (s.tf == FMT_F32);
    fsh = f32 ? 6'd23 : 6'd52;
    qr = s.q + {63'd0, s.rnd & (s.sticky | s.q[0])};
    infb = (f32 ? 64'd255 : 64'd2047) << fsh;
    bits = ({50'd0, s.ebase} << fsh) + qr;
    if (s.ovf || bits >= infb) bits = infb;
    lim = int_sat(s.sign, s.tf == FMT_I32);
    imag = s.q;
    clip_next = 1'b0;
    // Saturate only integer targets.
    if ((s.tf == FMT_I16 || s.tf == FMT_I32) && (s.ibig || s.q > lim)) begin
      imag = lim;
      clip_next = 1'b1;
    end
    ival = s.sign ? (64'd0 - imag) : imag;
    res_next = 64'd0;
    unique case (s.tf)
      FMT_I16: res_next = {48'd0, ival[15:0]};
      FMT_I32: res_next = {32'd0, ival[31:0]};
      FMT_F32: res_next = {32'd0, s.sign, bits[30:0]};
      default: res_next = {s.sign, bits[62:0]};
    endcase
    if (s.direct) begin
      res_next = s.err ? 64'd0 : s.res;
      clip_next = s.clip & ~s.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      s_valid <= in_valid;
      done <= s_valid;
    end
    s <= s_next;
    sample_out <= res_next;
    last_out <= s.last;
    clipped <= clip_next;
    format_error <= s.err;
  end

endmodule

### rtl/core/pcm_sample_format_convert_unit.sv
// Top level of the PCM sample format converter: config registers and pipeline.
// Depends on psfc_pkg, psfc_decode, psfc_norm and psfc_round.

// Converts one audio sample per request between int16, int32, float32 and
// float64 (codes 0..3 in source_format / target_format; any other code gives
// format_error with a zero sample). Requests are taken on start whenever busy
// is low, one per clock, with no gaps. Each result is marked by a one-cycle done
// strobe, in request order; the receiver cannot stall. The pipeline has five
// register stages: decode, two normalize stages (three shift steps each), align,
// round/pack. busy is high only during reset. Write the format registers only
// while no request is in flight.
module pcm_sample_format_convert_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] sample_in,
  input  logic        last_in,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  output logic        done,
  output logic [63:0] sample_out,
  output logic        last_out,
  output logic        clipped,
  output logic        format_error
);
  import psfc_pkg::*;

  localparam logic [0:0] REG_SOURCE = 1'b0;
  localparam logic [0:0] REG_TARGET = 1'b1;

  logic [2:0] source_format;
  logic [2:0] target_format;
  logic       accept;
  logic       dec_valid;
  logic       norm_valid;
  psfc_dec_t  dec_item;
  psfc_dec_t  norm_item;

  // Hold requests off only while reset is applied.
  assign busy = rst;
  assign accept = start & ~busy;

  // Format registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= FMT_I16;
      target_format <= FMT_I16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE: source_format <= cfg_data;
        REG_TARGET: target_format <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode the source and resolve specials, zero, and pass-through.
  psfc_decode u_decode (
    .clk(clk), .rst(rst), .in_valid(accept), .sample(sample_in), .last(last_in),
    .sf(source_format), .tf(target_format),
    .out_valid(dec_valid), .out_item(dec_item)
  );

  // Normalize the magnitude so its leading one sits at bit 63.
  psfc_norm u_norm (
    .clk(clk), .rst(rst), .in_valid(dec_valid), .in_item(dec_item),
    .out_valid(norm_valid), .out_item(norm_item)
  );

  // Align, round to nearest even or truncate and saturate, then pack.
  psfc_round u_round (
    .clk(clk), .rst(rst), .in_valid(norm_valid), .in_item(norm_item),
    .done(done), .sample_out(sample_out), .last_out(last_out),
    .clipped(clipped), .format_error(format_error)
  );

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done) else $error("result missing five clocks after request");
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5)) else $error("result without a request");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && format_error) |-> (sample_out == 64'd0 && !clipped))
    else $error("format error result not cleared");
`endif

endmodule

### tb/pcm_sample_format_convert_unit_test.sv
// Self-checking bench for pcm_sample_format_convert_unit: format conversions, flags.
// Depends on psfc_pkg and the converter RTL; a scoreboard class holds expected results.
module pcm_sample_format_convert_unit_test;
  import psfc_pkg::*;

  // Register indexes of the configuration port
  localparam logic [0:0] REG_SOURCE = 1'd0;
  localparam logic [0:0] REG_TARGET = 1'd1;
  // Unsupported format codes used in the run
  localparam logic [2:0] FMT_BAD_LOW  = 3'd4;
  localparam logic [2:0] FMT_BAD_MID  = 3'd5;
  localparam logic [2:0] FMT_BAD_TOP  = 3'd7;
  // Float classes
  localparam int CLS_FINITE = 0;
  localparam int CLS_INF    = 1;
  localparam int CLS_NAN    = 2;

  localparam int ITEMS_PER_SETTING = 64;
  localparam int QUIET_LIMIT       = 1000;
  localparam int DRAIN_CYCLES      = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] sample_in = '0;
  logic        last_in = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [2:0]  cfg_data = '0;
  logic        done;
  logic [63:0] sample_out;
  logic        last_out;
  logic        clipped;
  logic        format_error;

  pcm_sample_format_convert_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_in(sample_in), .last_in(last_in),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .sample_out(sample_out), .last_out(last_out),
    .clipped(clipped), .format_error(format_error)
  );

  always #5 clk = ~clk;

  // Decoded float: value = mag * 2^exp for finite numbers
  typedef struct {
    bit          sign;
    logic [63:0] mag;
    int          exp;
    int          cls;
    logic [63:0] frac;
  } float_parts_t;

  typedef struct {
    logic [63:0] sample;
    logic        last;
    logic        clip;
    logic        err;
  } converted_t;

  // Round mag * 2^e to nearest even into a float with f fraction bits and eb
  // exponent bits; underflow goes subnormal, overflow goes to infinity.
  function automatic logic [63:0] float_encode(bit s, logic [63:0] m, int e, int f, int eb);
    int          bias;
    int          maxe;
    int          p;
    int          shift;
    longint      ebase;
    logic [63:0] sbit;
    logic [63:0] inf;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] bits;
    bias = (1 << (eb - 1)) - 1;
    maxe = (1 << eb) - 1;
    sbit = 64'(s) << (f + eb);
    inf = sbit | (64'(maxe) << f);
    if (m == 0) return sbit;
    p = 63;
    while (!m[p]) p--;
    if (p + e + bias >= 1) begin
      shift = p - f;
      ebase = longint'(p) + e + bias - 1;
    end else begin
      shift = 1 - bias - f - e;
      ebase = 0;
    end
    if (ebase >= maxe - 1) return inf;
    if (shift <= 0) begin
      q = m << (-shift);
    end else if (shift >= 64) begin
      q = (shift == 64 && m > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
    end else begin
      rem = m & ((64'd1 << shift) - 64'd1);
      half = 64'd1 << (shift - 1);
      q = m >> shift;
      if (rem > half || (rem == half && q[0])) q++;
    end
    bits = (64'(ebase) << f) + q;
    if (bits >= (64'(maxe) << f)) return inf;
    return sbit | bits;
  endfunction

  function automatic float_parts_t float_decode(logic [63:0] raw, int f, int eb);
    float_parts_t v;
    int           bias;
    logic [63:0]  maxe;
    logic [63:0]  ef;
    bias = (1 << (eb - 1)) - 1;
    maxe = (64'd1 << eb) - 64'd1;
    ef = (raw >> f) & maxe;
    v.frac = raw & ((64'd1 << f) - 64'd1);
    v.sign = raw[f + eb];
    v.cls = CLS_FINITE;
    if (ef == maxe) begin
      v.cls = (v.frac != 0) ? CLS_NAN : CLS_INF;
      v.mag = 0;
      v.exp = 0;
    end else if (ef == 0) begin
      v.mag = v.frac;
      v.exp = 1 - bias - f;
    end else begin
      v.mag = v.frac | (64'd1 << f);
      v.exp = int'(ef) - bias - f;
    end
    return v;
  endfunction

  // Scale by 2^scale, truncate toward zero and saturate into a width-bit integer
  function automatic logic [63:0] float_to_int(float_parts_t v, int scale, int width,
                                               output bit clip);
    logic [63:0] lim;
    logic [63:0] mask;
    logic [63:0] mag;
    int          t;
    lim = (64'd1 << (width - 1)) - (v.sign ? 64'd0 : 64'd1);
    mask = (64'd1 << width) - 64'd1;
    t = v.exp + scale;
    clip = 1'b0;
    if (v.cls == CLS_NAN) begin
      clip = 1'b1;
      return 0;
    end
    if (v.cls == CLS_INF) begin
      mag = lim;
      clip = 1'b1;
    end else if (v.mag == 0) begin
      mag = 0;
    end else if (t >= 0) begin
      if (t >= 64 || v.mag > (lim >> t)) begin
        mag = lim;
        clip = 1'b1;
      end else begin
        mag = v.mag << t;
      end
    end else begin
      mag = (-t >= 64) ? 64'd0 : (v.mag >> (-t));
      if (mag > lim) begin
        mag = lim;
        clip = 1'b1;
      end
    end
    return (v.sign ? (64'd0 - mag) : mag) & mask;
  endfunction

  function automatic converted_t convert_sample(logic [2:0] sf, logic [2:0] tf,
                                                logic [63:0] x, logic last);
    converted_t   r;
    float_parts_t v;
    bit           neg;
    bit           clip;
    logic [63:0]  mag;
    int           scale;
    r.sample = 0;
    r.last = last;
    r.clip = 1'b0;
    r.err = 1'b0;
    clip = 1'b0;
    if (sf > FMT_F64 || tf > FMT_F64) begin
      r.err = 1'b1;
    end else if (sf == tf) begin
      if (sf == FMT_I16) r.sample = {48'd0, x[15:0]};
      else if (sf == FMT_F64) r.sample = x;
      else r.sample = {32'd0, x[31:0]};
    end else if (sf == FMT_I16 || sf == FMT_I32) begin
      if (sf == FMT_I16) begin
        neg = x[15];
        mag = neg ? 64'(-$signed({1'b1, x[15:0]})) : 64'(x[15:0]);
        scale = 15;
      end else begin
        neg = x[31];
        mag = neg ? 64'(-$signed({1'b1, x[31:0]})) : 64'(x[31:0]);
        scale = 31;
      end
      case (tf)
        FMT_I32: r.sample = (x << 16) & 64'hFFFF_FFFF;
        FMT_I16: r.sample = (x >> 16) & 64'hFFFF;
        FMT_F32: r.sample = float_encode(1'b0, mag, -scale, 23, 8) | (64'(neg) << 31);
        default: r.sample = float_encode(1'b0, mag, -scale, 52, 11) | (64'(neg) << 63);
      endcase
    end else begin
      v = (sf == FMT_F32) ? float_decode({32'd0, x[31:0]}, 23, 8) : float_decode(x, 52, 11);
      case (tf)
        FMT_I16: r.sample = float_to_int(v, 15, 16, clip);
        FMT_I32: r.sample = float_to_int(v, 31, 32, clip);
        FMT_F64: begin
          if (v.cls == CLS_FINITE) r.sample = float_encode(v.sign, v.mag, v.exp, 52, 11);
          else r.sample = (64'(v.sign) << 63) | (64'h7FF << 52) |
                          ((v.cls == CLS_NAN) ? ((64'd1 << 51) | (v.frac << 29)) : 64'd0);
        end
        default: begin
          if (v.cls == CLS_FINITE) r.sample = float_encode(v.sign, v.mag, v.exp, 23, 8);
          else r.sample = (64'(v.sign) << 31) | (64'hFF << 23) |
                          ((v.cls == CLS_NAN) ? ((64'd1 << 22) | (v.frac >> 29)) : 64'd0);
        end
      endcase
      r.clip = clip;
    end
    return r;
  endfunction

  // Tracks the format registers and the conversions still owed by the block
  class conv_scoreboard;
    converted_t owed[$];
    logic [2:0] source_fmt = FMT_I16;
    logic [2:0] target_fmt = FMT_I16;
    int         fails = 0;

    function void note_request(logic [63:0] s, logic l);
      owed.push_back(convert_sample(source_fmt, target_fmt, s, l));
    endfunction

    function void check_result(logic [63:0] s, logic l, logic c, logic e);
      converted_t exp_r;
      if (owed.size() == 0) begin
        $error("unexpected result sample_out=%h", s);
        fails++;
        return;
      end
      exp_r = owed.pop_front();
      if (s !== exp_r.sample) begin
        $error("sample_out expected %h actual %h", exp_r.sample, s);
        fails++;
      end
      if (l !== exp_r.last) begin
        $error("last_out expected %b actual %b", exp_r.last, l);
        fails++;
      end
      if (c !== exp_r.clip) begin
        $error("clipped expected %b actual %b", exp_r.clip, c);
        fails++;
      end
      if (e !== exp_r.err) begin
        $error("format_error expected %b actual %b", exp_r.err, e);
        fails++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  conv_scoreboard sb = new();
  int             quiet_cycles = 0;
  logic [63:0]    corner_samples[$];

  // Note accepted requests and check results on the same edge the DUT sees them
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(sample_in, last_in);
      if (done) sb.check_result(sample_out, last_out, clipped, format_error);
    end
  end

  // Watchdog: give up after a long stretch with no traffic
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Hold start high until the request is taken; then optionally drop into a gap
  task automatic send_request(logic [63:0] s, logic l);
    int gap;
    start <= 1'b1;
    sample_in <= s;
    last_in <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leave the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [0:0] idx, logic [2:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_SOURCE) sb.source_fmt = val;
    else sb.target_fmt = val;
  endtask

  task automatic set_formats(logic [2:0] sf, logic [2:0] tf);
    drain();
    write_reg(REG_SOURCE, sf);
    write_reg(REG_TARGET, tf);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random bits with a float exponent steered toward the interesting boundaries
  function automatic logic [63:0] random_sample(logic [2:0] sf);
    logic [63:0] r;
    int          ex;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3: r = corner_samples[$urandom_range(0, corner_samples.size() - 1)];
      default: begin
        if (sf == FMT_F32) begin
          case ($urandom_range(0, 3))
            0: ex = 0;
            1: ex = 255;
            default: ex = 127 + $urandom_range(0, 50) - 25;
          endcase
          r[30:23] = ex[7:0];
          if ($urandom_range(0, 3) == 0) r[22:0] = '0;
        end else if (sf == FMT_F64) begin
          case ($urandom_range(0, 6))
            0: ex = 0;
            1: ex = 2047;
            2: ex = 1023 - 150 + $urandom_range(0, 30);
            3: ex = 1023 + 124 + $urandom_range(0, 6);
            default: ex = 1023 + $urandom_range(0, 50) - 25;
          endcase
          r[62:52] = ex[10:0];
          // exact halfway or exactly representable for narrowing
          case ($urandom_range(0, 3))
            0: r[28:0] = 29'h1000_0000;
            1: r[28:0] = '0;
            default: ;
          endcase
        end else begin
          case ($urandom_range(0, 3))
            0: r[31:0] = 32'h8000_0000;
            1: r[31:0] = 32'h7FFF_FFFF;
            2: r[15:0] = 16'h8000;
            default: ;
          endcase
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    logic [2:0] fmt_list[$];
    logic [2:0] sf;
    logic [2:0] tf;

    corner_samples = '{
      64'h0, 64'h8000_0000_0000_0000, 64'h8000_0000, 64'h7FFF, 64'h8000,
      64'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7F80_0000, 64'hFF80_0000,
      64'h7FC0_0001, 64'h7F80_0001, 64'h7FF0_0000_0000_0000,
      64'hFFF8_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'h1,
      64'h7F7F_FFFF, 64'h3F80_0000, 64'h3FF0_0000_0000_0000,
      64'hBFF0_0000_0000_0000, 64'h40E0_0000_0000_0000,
      64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000,
      64'h47EF_FFFF_F000_0000, 64'h36A0_0000_0000_0000
    };
    fmt_list = '{FMT_I16, FMT_I32, FMT_F32, FMT_F64, FMT_BAD_LOW};

    // Hold reset, then release it and wait for the block to come ready
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed corners: narrowing covers rounding, subnormals, NaN and infinity
    set_formats(FMT_F64, FMT_F32);
    foreach (corner_samples[i]) send_request(corner_samples[i], i[0]);

    // Every pair of the four formats and code 4, then the unsupported codes 5 and 7
    foreach (fmt_list[a]) begin
      foreach (fmt_list[b]) begin
        set_formats(fmt_list[a], fmt_list[b]);
        repeat (ITEMS_PER_SETTING) send_request(random_sample(fmt_list[a]), $urandom_range(0, 1));
      end
    end
    for (int k = 0; k < 3; k++) begin
      sf = (k == 0) ? FMT_BAD_TOP : ((k == 1) ? FMT_I16 : FMT_BAD_MID);
      tf = (k == 0) ? FMT_I16 : FMT_BAD_TOP;
      set_formats(sf, tf);
      repeat (ITEMS_PER_SETTING / 2) send_request(random_sample(FMT_F64), $urandom_range(0, 1));
    end

    drain();
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### pcm_sample_format_convert_unit.f
rtl/core/psfc_pkg.sv
rtl/core/psfc_decode.sv
rtl/core/psfc_norm.sv
rtl/core/psfc_round.sv
rtl/core/pcm_sample_format_convert_unit.sv
tb/pcm_sample_format_convert_unit_test.sv
